// ----- rtl/shift_xor_rng_percent_roll_unit_assert.svh -----
// assertion macros for the shift/xor random source
`ifndef SHIFT_XOR_RNG_PERCENT_ROLL_UNIT_ASSERT_SVH
`define SHIFT_XOR_RNG_PERCENT_ROLL_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srpr assertion failed");

// next-cycle implication, checked out of reset
`define SRPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srpr assertion failed");

`endif

// ----- rtl/srpr_pkg.sv -----
package srpr_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned PctW = 7;
  localparam int unsigned ThrW = 8;

  localparam logic [WordW-1:0] SeedResetLow = 16'd4660;
  localparam logic [WordW-1:0] SeedResetMid = 16'd22136;
  localparam logic [WordW-1:0] SeedResetHigh = 16'd39612;

  localparam logic [PctW-1:0] PctScale = 7'd100;

  typedef enum logic [1:0] {
    REQ_RAW = 2'd0,
    REQ_SINGLE = 2'd1,
    REQ_DOUBLE = 2'd2,
    REQ_RELOAD = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_SEED_LOW = 2'd0,
    CFG_SEED_MID = 2'd1,
    CFG_SEED_HIGH = 2'd2,
    CFG_NONE = 2'd3
  } cfg_index_e;

  // one transaction after the draw stage
  typedef struct packed {
    req_type_e kind;
    logic [ThrW-1:0] threshold;
    logic [WordW-1:0] draw_a;
    logic [WordW-1:0] draw_b;
  } draw_t;

endpackage

// ----- rtl/shift_xor_rng_percent_roll_unit.sv -----
// shift/xor pseudo-random source with percent rolls
// input channel: in_valid_i/in_ready_o carry req_type_i (raw draw, single
// roll, double averaged roll, reload seeds) and threshold_i
// output channel: out_valid_o/out_ready_i carry raw_value_o, percent_o and
// hit_o, one result per input transaction, in order
// config port: cfg_we_i writes cfg_data_i into start seed register
// cfg_index_i (low, mid, high); index 3 is ignored. the start seeds take
// effect at the next reload request; reset restores the defaults
// the result passes the draw register and then the result register; throughput is
// one transaction per cycle while the receiver does not stall, set by the
// combinational seed update (one or two chained shift/add/xor draws) at the
// input side
// reset loads the seed words and start registers with their default
// values and empties both pipeline registers
// when the receiver stalls, the result register holds; the draw register
// behind it takes one more transaction only if empty, then in_ready_o drops
module shift_xor_rng_percent_roll_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [srpr_pkg::WordW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [srpr_pkg::ThrW-1:0]     threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srpr_pkg::WordW-1:0]    raw_value_o,
  output logic [srpr_pkg::PctW-1:0]     percent_o,
  output logic                          hit_o
);

  logic            s1_valid;
  logic            s1_ready;
  srpr_pkg::draw_t s1;

  srpr_draw u_draw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .threshold_i (threshold_i),
    .s1_valid_o  (s1_valid),
    .s1_ready_i  (s1_ready),
    .s1_o        (s1)
  );

  srpr_roll u_roll (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_i        (s1),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .raw_value_o (raw_value_o),
    .percent_o   (percent_o),
    .hit_o       (hit_o)
  );

endmodule

// ----- rtl/srpr_draw.sv -----
module srpr_draw (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [srpr_pkg::WordW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [srpr_pkg::ThrW-1:0]     threshold_i,
  output logic                          s1_valid_o,
  input  logic                          s1_ready_i,
  output srpr_pkg::draw_t               s1_o
);

  logic [srpr_pkg::WordW-1:0] start_low_q, start_mid_q, start_high_q;
  logic [srpr_pkg::WordW-1:0] seed0_q, seed1_q, seed2_q;
  logic [srpr_pkg::WordW-1:0] seed0_d, seed1_d, seed2_d;
  logic [srpr_pkg::WordW-1:0] draw1, draw2;
  logic                       s1_valid_q;
  srpr_pkg::draw_t            s1_q, s1_d;
  srpr_pkg::req_type_e        kind;
  srpr_pkg::cfg_index_e       cfg_idx;
  logic                       accept;

  function automatic logic [srpr_pkg::WordW-1:0] next_word(
    input logic [srpr_pkg::WordW-1:0] s0,
    input logic [srpr_pkg::WordW-1:0] s1,
    input logic [srpr_pkg::WordW-1:0] s2
  );
    logic [srpr_pkg::WordW-1:0] sum;
    sum = {s1[4:0], 11'b0} + {5'b0, s0[15:5]};
    return sum ^ {s2[14:0], s1[15]};
  endfunction

  assign kind = srpr_pkg::req_type_e'(req_type_i);
  assign cfg_idx = srpr_pkg::cfg_index_e'(cfg_index_i);
  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept = in_valid_i && in_ready_o;

  // second draw chains off the first
  assign draw1 = next_word(seed0_q, seed1_q, seed2_q);
  assign draw2 = next_word(draw1, seed0_q, seed1_q);

  always_comb begin
    seed0_d = seed0_q;
    seed1_d = seed1_q;
    seed2_d = seed2_q;
    case (kind)
      srpr_pkg::REQ_RAW, srpr_pkg::REQ_SINGLE: begin
        seed0_d = draw1;
        seed1_d = seed0_q;
        seed2_d = seed1_q;
      end
      srpr_pkg::REQ_DOUBLE: begin
        seed0_d = draw2;
        seed1_d = draw1;
        seed2_d = seed0_q;
      end
      srpr_pkg::REQ_RELOAD: begin
        seed0_d = start_low_q;
        seed1_d = start_mid_q;
        seed2_d = start_high_q;
      end
      default: begin
        seed0_d = seed0_q;
      end
    endcase
  end

  always_comb begin
    s1_d.kind = kind;
    s1_d.threshold = threshold_i;
    s1_d.draw_a = draw1;
    s1_d.draw_b = draw2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= srpr_pkg::SeedResetLow;
      start_mid_q <= srpr_pkg::SeedResetMid;
      start_high_q <= srpr_pkg::SeedResetHigh;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        srpr_pkg::CFG_SEED_LOW: start_low_q <= cfg_data_i;
        srpr_pkg::CFG_SEED_MID: start_mid_q <= cfg_data_i;
        srpr_pkg::CFG_SEED_HIGH: start_high_q <= cfg_data_i;
        default: start_low_q <= start_low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed0_q <= srpr_pkg::SeedResetLow;
      seed1_q <= srpr_pkg::SeedResetMid;
      seed2_q <= srpr_pkg::SeedResetHigh;
    end else if (accept) begin
      seed0_q <= seed0_d;
      seed1_q <= seed1_d;
      seed2_q <= seed2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o = s1_q;

  `include "shift_xor_rng_percent_roll_unit_assert.svh"

  // reload copies the start registers into the seed words
  `SRPR_ASSERT_NEXT(a_reload_loads, accept && kind == srpr_pkg::REQ_RELOAD && !cfg_we_i, seed0_q == $past(start_low_q) && seed1_q == $past(start_mid_q) && seed2_q == $past(start_high_q))
  // a single draw shifts the seed words down by one
  `SRPR_ASSERT_NEXT(a_single_shift, accept && (kind == srpr_pkg::REQ_RAW || kind == srpr_pkg::REQ_SINGLE), seed1_q == $past(seed0_q) && seed2_q == $past(seed1_q))
  // seeds only move on an accepted transaction
  `SRPR_ASSERT_NEXT(a_seed_hold, !accept, seed0_q == $past(seed0_q) && seed2_q == $past(seed2_q))

endmodule

// ----- rtl/srpr_roll.sv -----
module srpr_roll (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  output logic                          s1_ready_o,
  input  srpr_pkg::draw_t               s1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srpr_pkg::WordW-1:0]    raw_value_o,
  output logic [srpr_pkg::PctW-1:0]     percent_o,
  output logic                          hit_o
);

  localparam int unsigned ProdW = srpr_pkg::WordW + srpr_pkg::PctW;

  logic [ProdW-1:0]            prod_a, prod_b;
  logic [srpr_pkg::PctW-1:0]   pct_a, pct_b;
  logic [srpr_pkg::PctW:0]     pct_sum;
  logic [srpr_pkg::WordW-1:0]  raw_d, raw_q;
  logic [srpr_pkg::PctW-1:0]   pct_d, pct_q;
  logic                        hit_d, hit_q;
  logic                        out_valid_q;
  logic                        roll;

  assign s1_ready_o = !out_valid_q || out_ready_i;

  // percent is the top bits of value * 100
  assign prod_a = {{srpr_pkg::PctW{1'b0}}, s1_i.draw_a} * {{srpr_pkg::WordW{1'b0}}, srpr_pkg::PctScale};
  assign prod_b = {{srpr_pkg::PctW{1'b0}}, s1_i.draw_b} * {{srpr_pkg::WordW{1'b0}}, srpr_pkg::PctScale};
  assign pct_a = prod_a[ProdW-1:srpr_pkg::WordW];
  assign pct_b = prod_b[ProdW-1:srpr_pkg::WordW];
  assign pct_sum = {1'b0, pct_a} + {1'b0, pct_b};

  always_comb begin
    raw_d = '0;
    pct_d = '0;
    roll = 1'b0;
    case (s1_i.kind)
      srpr_pkg::REQ_RAW: begin
        raw_d = s1_i.draw_a;
        pct_d = pct_a;
      end
      srpr_pkg::REQ_SINGLE: begin
        raw_d = s1_i.draw_a;
        pct_d = pct_a;
        roll = 1'b1;
      end
      srpr_pkg::REQ_DOUBLE: begin
        raw_d = s1_i.draw_b;
        pct_d = pct_sum[srpr_pkg::PctW:1];
        roll = 1'b1;
      end
      default: begin
        raw_d = '0;
      end
    endcase
    hit_d = roll && (s1_i.threshold > {1'b0, pct_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      raw_q <= raw_d;
      pct_q <= pct_d;
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign raw_value_o = raw_q;
  assign percent_o = pct_q;
  assign hit_o = hit_q;

  `include "shift_xor_rng_percent_roll_unit_assert.svh"

  // scaled percent stays within 0..99
  `SRPR_ASSERT_NOW(a_pct_range, s1_valid_i, pct_d < srpr_pkg::PctScale)
  // a reload transaction gives an all-zero result
  `SRPR_ASSERT_NEXT(a_reload_zero, s1_valid_i && s1_ready_o && s1_i.kind == srpr_pkg::REQ_RELOAD, raw_q == '0 && pct_q == '0 && !hit_q)
  // raw draws never report a hit
  `SRPR_ASSERT_NOW(a_raw_no_hit, s1_i.kind == srpr_pkg::REQ_RAW, !hit_d)

endmodule

// ----- dv/shift_xor_rng_percent_roll_unit_test.sv -----
module shift_xor_rng_percent_roll_unit_test;
  import srpr_pkg::*;

  localparam int HalfPeriod = 2;
  localparam int QuietLimit = 4000;
  localparam int RandomPhases = 8;
  localparam int PhaseItems = 195;

  typedef struct packed {
    req_type_e       kind;
    logic [ThrW-1:0] thr;
  } roll_req_t;

  typedef struct packed {
    logic [WordW-1:0] raw;
    logic [PctW-1:0]  pct;
    logic             hit;
  } roll_result_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = CFG_NONE;
  logic [WordW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       req_type_i = REQ_RAW;
  logic [ThrW-1:0]  threshold_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] raw_value_o;
  logic [PctW-1:0]  percent_o;
  logic             hit_o;

  always #(HalfPeriod) clk_i = ~clk_i;

  shift_xor_rng_percent_roll_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .threshold_i (threshold_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .raw_value_o (raw_value_o),
    .percent_o   (percent_o),
    .hit_o       (hit_o)
  );

  // generator state as the block should hold it
  logic [WordW-1:0] start_seed [3];
  logic [WordW-1:0] seed_word [3];

  roll_req_t    pending_reqs[$];
  roll_result_t rolls_due[$];

  int        fail_count = 0;
  int        quiet_cycles = 0;
  logic      in_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_cycle = 0;
  rx_mode_e  rx_mode = RX_ALWAYS;
  roll_req_t next_req;
  roll_req_t seen_req;
  roll_result_t want;

  function automatic logic [WordW-1:0] draw_word();
    logic [WordW-1:0] mixed;
    mixed = {seed_word[1][4:0], 11'd0} + {5'd0, seed_word[0][15:5]};
    mixed = mixed ^ {seed_word[2][14:0], seed_word[1][15]};
    seed_word[2] = seed_word[1];
    seed_word[1] = seed_word[0];
    seed_word[0] = mixed;
    return mixed;
  endfunction

  function automatic logic [PctW-1:0] to_pct(logic [WordW-1:0] v);
    logic [31:0] prod;
    prod = 32'(v) * 32'd100;
    return prod[16 +: PctW];
  endfunction

  function automatic roll_result_t predict_roll(roll_req_t r);
    roll_result_t res;
    logic [PctW:0] pct_sum;
    res = '0;
    case (r.kind)
      REQ_RAW: begin
        res.raw = draw_word();
        res.pct = to_pct(res.raw);
      end
      REQ_SINGLE: begin
        res.raw = draw_word();
        res.pct = to_pct(res.raw);
        res.hit = r.thr > res.pct;
      end
      REQ_DOUBLE: begin
        pct_sum = to_pct(draw_word());
        res.raw = draw_word();
        pct_sum = pct_sum + to_pct(res.raw);
        res.pct = pct_sum[PctW:1];
        res.hit = r.thr > res.pct;
      end
      default: begin
        for (int i = 0; i < 3; i++) seed_word[i] = start_seed[i];
      end
    endcase
    return res;
  endfunction

  function automatic void queue_req(req_type_e kind, int thr);
    roll_req_t r;
    r.kind = kind;
    r.thr = thr[ThrW-1:0];
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_random_reqs(int count);
    int pick;
    req_type_e kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) kind = REQ_RELOAD;
      else if (pick < 30) kind = REQ_RAW;
      else if (pick < 65) kind = REQ_SINGLE;
      else kind = REQ_DOUBLE;
      queue_req(kind,
                $urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 101));
    end
  endfunction

  function automatic logic [WordW-1:0] pick_seed();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return WordW'($urandom);
    endcase
  endfunction

  task automatic write_start_seed(cfg_index_e idx, logic [WordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != CFG_NONE) start_seed[int'(idx)] = value;
  endtask

  // all requests sent and all rolls back, then a short settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || rolls_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending_reqs.size() != 0 && gap_left == 0) begin
        next_req = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= next_req.kind;
        threshold_i <= next_req.thr;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver: the backpressure style is redrawn at random from always, coin, sparse and periodic
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rx_cycle % 7) < 4;
    endcase
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (rolls_due.size() == 0) begin
          $display("%0t: result with none expected: raw_value %h percent %0d hit %b",
                   $time, raw_value_o, percent_o, hit_o);
          fail_count++;
        end else begin
          want = rolls_due.pop_front();
          if (raw_value_o !== want.raw) begin
            $display("%0t: raw_value expected %h actual %h", $time, want.raw, raw_value_o);
            fail_count++;
          end
          if (percent_o !== want.pct) begin
            $display("%0t: percent expected %0d actual %0d", $time, want.pct, percent_o);
            fail_count++;
          end
          if (hit_o !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, hit_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen_req.kind = req_type_e'(req_type_i);
        seen_req.thr = threshold_i;
        rolls_due.push_back(predict_roll(seen_req));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    start_seed[0] = SeedResetLow;
    start_seed[1] = SeedResetMid;
    start_seed[2] = SeedResetHigh;
    for (int i = 0; i < 3; i++) seed_word[i] = start_seed[i];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default seeds, every request kind, threshold extremes
    queue_req(REQ_RAW, 0);
    queue_req(REQ_SINGLE, 0);
    queue_req(REQ_SINGLE, 255);
    queue_req(REQ_SINGLE, 99);
    queue_req(REQ_DOUBLE, 100);
    queue_req(REQ_DOUBLE, 0);
    queue_req(REQ_RAW, 255);
    queue_req(REQ_DOUBLE, 255);
    queue_req(REQ_RELOAD, 7);
    queue_req(REQ_RAW, 128);
    queue_req(REQ_SINGLE, 1);
    wait_idle();

    // all-zero seeds; the unused index must not disturb anything
    write_start_seed(CFG_SEED_LOW, '0);
    write_start_seed(CFG_SEED_MID, '0);
    write_start_seed(CFG_SEED_HIGH, '0);
    write_start_seed(CFG_NONE, '1);
    queue_req(REQ_RAW, 0);        // old state still running until reload
    queue_req(REQ_RELOAD, 255);
    queue_req(REQ_RAW, 0);
    queue_req(REQ_SINGLE, 0);
    queue_req(REQ_SINGLE, 1);
    queue_req(REQ_DOUBLE, 1);
    wait_idle();

    // all-ones seeds
    write_start_seed(CFG_SEED_LOW, '1);
    write_start_seed(CFG_SEED_MID, '1);
    write_start_seed(CFG_SEED_HIGH, '1);
    write_start_seed(CFG_NONE, '0);
    queue_req(REQ_RELOAD, 0);
    queue_req(REQ_RAW, 0);
    queue_req(REQ_DOUBLE, 255);
    queue_req(REQ_SINGLE, 0);
    queue_req(REQ_SINGLE, 50);
    queue_req(REQ_RAW, 0);
    wait_idle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      write_start_seed(CFG_SEED_LOW, pick_seed());
      write_start_seed(CFG_SEED_MID, pick_seed());
      write_start_seed(CFG_SEED_HIGH, pick_seed());
      if ($urandom_range(0, 2) == 0) write_start_seed(CFG_NONE, WordW'($urandom));
      queue_random_reqs(PhaseItems);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
